/* hdl/prfd_pkg.sv */
package prfd_pkg;

	localparam int FRAME_PIXELS_BITS = 25;
	localparam int BYTE_BITS         = 8;
	localparam int FRAME_NUM_BITS    = 16;
	localparam int CHANNEL_BITS      = 2;
	localparam int CFG_INDEX_BITS    = 2;

	localparam logic [FRAME_PIXELS_BITS-1:0] FRAME_PIXELS_RESET = 25'd1;
	localparam logic [BYTE_BITS-1:0]         START_MARKER_RESET = 8'd83;
	localparam logic [BYTE_BITS-1:0]         END_MARKER_RESET   = 8'd69;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_PIXELS = 2'd0,
		REG_START_MARKER = 2'd1,
		REG_END_MARKER   = 2'd2
	} cfg_reg_t;

	localparam logic [CHANNEL_BITS-1:0] CH_RED  = 2'd0;
	localparam logic [CHANNEL_BITS-1:0] CH_BLUE = 2'd2;

	typedef enum logic [2:0] {
		PH_SEEK    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_REPEAT  = 3'd2,
		PH_LITERAL = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	typedef struct packed {
		logic [FRAME_PIXELS_BITS-1:0] frame_pixels;
		logic [BYTE_BITS-1:0]         start_marker;
		logic [BYTE_BITS-1:0]         end_marker;
	} cfg_t;

	typedef struct packed {
		logic                         write_valid;
		logic [CHANNEL_BITS-1:0]      color_channel;
		logic [FRAME_PIXELS_BITS-1:0] pixel_index;
		logic [BYTE_BITS-1:0]         pixel_value;
		logic [BYTE_BITS-1:0]         run_length;
		logic [FRAME_NUM_BITS-1:0]    frame_seq;
		logic                         frame_done;
		logic                         stream_done;
		logic                         overrun;
	} result_t;

endpackage

/* hdl/prfd_cfg_regs.sv */
module prfd_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [prfd_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  logic [prfd_pkg::FRAME_PIXELS_BITS-1:0] wr_data,
	output prfd_pkg::cfg_t                       cfg
);
	import prfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_pixels <= FRAME_PIXELS_RESET;
			cfg_q.start_marker <= START_MARKER_RESET;
			cfg_q.end_marker   <= END_MARKER_RESET;
		end else if (wr_en) begin
			// index beyond the register list: drop the word
			unique case (wr_index)
				REG_FRAME_PIXELS: cfg_q.frame_pixels <= wr_data;
				REG_START_MARKER: cfg_q.start_marker <= wr_data[BYTE_BITS-1:0];
				REG_END_MARKER:   cfg_q.end_marker   <= wr_data[BYTE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/prfd_decode.sv */
module prfd_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [prfd_pkg::BYTE_BITS-1:0] in_byte,
	input  prfd_pkg::cfg_t                cfg,
	output prfd_pkg::result_t             res
);
	import prfd_pkg::*;

	localparam int SUM_BITS = FRAME_PIXELS_BITS + 1;

	phase_t                       phase_q, phase_d;
	logic [CHANNEL_BITS-1:0]      ch_q, ch_d;
	logic [FRAME_PIXELS_BITS-1:0] pc_q, pc_d;
	logic [BYTE_BITS-1:0]         lit_left_q, lit_left_d;
	logic [BYTE_BITS-1:0]         rep_cnt_q, rep_cnt_d;
	logic [FRAME_NUM_BITS-1:0]    frame_cnt_q;

	logic                         pc_below;
	logic                         lit_last;
	logic [SUM_BITS-1:0]          pc_rep_sum;
	logic [SUM_BITS-1:0]          pc_after;
	logic                         plane_full;
	logic                         pkt_end;
	logic                         frame_end;
	logic                         rep_clip;
	logic [BYTE_BITS-1:0]         room;
	logic [BYTE_BITS-1:0]         rep_run;
	logic                         is_end, is_start;
	logic                         done;
	logic [BYTE_BITS:0]           rep_from_hdr;

	// shared packet-end terms
	always_comb begin
		pc_below     = pc_q < cfg.frame_pixels;
		lit_last     = lit_left_q <= BYTE_BITS'(1);
		pc_rep_sum   = SUM_BITS'(pc_q) + SUM_BITS'(rep_cnt_q);
		pc_after     = (phase_q == PH_REPEAT) ? pc_rep_sum
		             : SUM_BITS'(pc_q) + SUM_BITS'(pc_below);
		plane_full   = pc_after >= SUM_BITS'(cfg.frame_pixels);
		pkt_end      = (phase_q == PH_REPEAT) || (phase_q == PH_LITERAL && lit_last);
		frame_end    = pkt_end && plane_full && (ch_q >= CH_BLUE);
		rep_clip     = pc_rep_sum > SUM_BITS'(cfg.frame_pixels);
		room         = BYTE_BITS'(cfg.frame_pixels - pc_q);
		rep_run      = rep_clip ? (pc_below ? room : '0) : rep_cnt_q;
		is_end       = in_byte == cfg.end_marker;
		is_start     = in_byte == cfg.start_marker;
		// header h < 0: repeat 2 - h = 258 - byte times
		rep_from_hdr = (BYTE_BITS+1)'(258) - {1'b0, in_byte};
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SEEK: begin
				if (is_end) begin
					phase_d = PH_DONE;
				end else if (is_start) begin
					phase_d = (cfg.frame_pixels == '0) ? PH_SEEK : PH_HEADER;
				end
			end
			PH_HEADER:  phase_d = in_byte[BYTE_BITS-1] ? PH_REPEAT : PH_LITERAL;
			PH_REPEAT:  phase_d = frame_end ? PH_SEEK : PH_HEADER;
			PH_LITERAL: begin
				if (lit_last) begin
					phase_d = frame_end ? PH_SEEK : PH_HEADER;
				end
			end
			default:    phase_d = PH_DONE;
		endcase
	end

	// counters and result
	always_comb begin
		ch_d       = ch_q;
		pc_d       = pc_q;
		lit_left_d = lit_left_q;
		rep_cnt_d  = rep_cnt_q;
		done       = 1'b0;
		res        = '0;
		res.color_channel = ch_q;
		res.frame_seq     = frame_cnt_q;
		unique case (phase_q)
			PH_SEEK: begin
				if (!is_end && is_start) begin
					ch_d = CH_RED;
					pc_d = '0;
					done = cfg.frame_pixels == '0;
				end
			end
			PH_HEADER: begin
				if (in_byte[BYTE_BITS-1]) begin
					rep_cnt_d = rep_from_hdr[BYTE_BITS-1:0];
				end else begin
					lit_left_d = in_byte + BYTE_BITS'(1);
				end
			end
			PH_REPEAT: begin
				res.overrun = rep_clip;
				if (rep_run != '0) begin
					res.write_valid = 1'b1;
					res.pixel_index = pc_q;
					res.pixel_value = in_byte;
					res.run_length  = rep_run;
				end
				rep_cnt_d = '0;
				pc_d      = pc_after[FRAME_PIXELS_BITS-1:0];
			end
			PH_LITERAL: begin
				if (pc_below) begin
					res.write_valid = 1'b1;
					res.pixel_index = pc_q;
					res.pixel_value = in_byte;
					res.run_length  = BYTE_BITS'(1);
				end else begin
					res.overrun = 1'b1;
				end
				if (lit_left_q != '0) begin
					lit_left_d = lit_left_q - BYTE_BITS'(1);
				end
				pc_d = pc_after[FRAME_PIXELS_BITS-1:0];
			end
			default: ;
		endcase
		// plane full at a packet end: move to the next channel
		if (pkt_end && plane_full) begin
			pc_d = '0;
			ch_d = (ch_q >= CH_BLUE) ? CH_RED : ch_q + CHANNEL_BITS'(1);
			done = ch_q >= CH_BLUE;
		end
		res.frame_done  = done;
		res.stream_done = phase_d == PH_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEEK;
			ch_q        <= CH_RED;
			pc_q        <= '0;
			lit_left_q  <= '0;
			rep_cnt_q   <= '0;
			frame_cnt_q <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			ch_q       <= ch_d;
			pc_q       <= pc_d;
			lit_left_q <= lit_left_d;
			rep_cnt_q  <= rep_cnt_d;
			if (done) begin
				frame_cnt_q <= frame_cnt_q + FRAME_NUM_BITS'(1);
			end
		end
	end

endmodule

/* hdl/planar_rle_frame_decoder.sv */
// Planar run-length frame decoder. Takes one encoded byte per word on s_t* and
// returns one result word per byte on m_t*, in order. A byte is registered on
// input, decoded against the block state combinationally, and its result is
// held in an output register, so a new byte is taken every cycle while the
// output is being consumed. Outside a frame bytes are skipped until the start
// marker; the end marker stops the stream for good (it wins if both markers are
// equal). Inside a frame the red, green and blue planes are decoded in turn; a
// header byte h (signed) repeats the next byte 2-h times when negative, or
// copies the next h+1 bytes. Each repeat result describes a run (pixel_index,
// run_length); pixels at or past frame_pixels are dropped and reported by
// overrun. m_tlast marks the byte that completes the blue plane, or a start
// marker while frame_pixels is 0. Configuration registers (0 frame_pixels,
// 1 start_marker, 2 end_marker) are written through cfg_*; the user must write
// only while no byte is in flight (not enforced); cfg_ready is always high.
module planar_rle_frame_decoder #(
	parameter int PIXEL_INDEX_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [prfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [prfd_pkg::FRAME_PIXELS_BITS-1:0] cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [7:0]                             s_tdata,  // in_byte
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// pixel_index, pixel_value, run_length, frame_seq, stream_done, overrun
	output logic [((PIXEL_INDEX_BITS+34+7)/8)*8-1:0] m_tdata,
	output logic [2:0]                             m_tuser,  // write_valid, color_channel
	output logic                                   m_tlast   // frame_done
);
	import prfd_pkg::*;

	localparam int TDATA_BITS = ((PIXEL_INDEX_BITS + 34 + 7) / 8) * 8;
	localparam int PAYLOAD_BITS = PIXEL_INDEX_BITS + 34;

	cfg_t                 cfg;
	result_t              res;
	result_t              res_s2;
	logic                 vld_s1, vld_s2;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 adv_s2;
	logic                 en;
	logic [31:0]          idx_ext;

	assign cfg_ready = 1'b1;

	prfd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv_s2   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s2;
	assign en       = vld_s1 && adv_s2;

	prfd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
			end else if (adv_s2) begin
				vld_s1 <= 1'b0;
			end
			if (en) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (en) begin
			res_s2 <= res;
		end
	end

	assign idx_ext  = 32'(res_s2.pixel_index);
	assign m_tvalid = vld_s2;
	assign m_tdata  = TDATA_BITS'(PAYLOAD_BITS'({res_s2.overrun, res_s2.stream_done,
	                  res_s2.frame_seq, res_s2.run_length, res_s2.pixel_value,
	                  idx_ext[PIXEL_INDEX_BITS-1:0]}));
	assign m_tuser  = {res_s2.color_channel, res_s2.write_valid};
	assign m_tlast  = res_s2.frame_done;

endmodule
